### hw/rtl/mwem_pkg.sv
// Package for the Microwire EEPROM master: sequence steps, opcodes and frame constants.
// No dependencies.
package mwem_pkg;

  localparam int unsigned WORDS = 64;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_PRE    = 3'd1,
    ST_EWEN   = 3'd2,
    ST_WRITE  = 3'd3,
    ST_EWDS   = 3'd4,
    ST_VERIFY = 3'd5,
    ST_SUM    = 3'd6,
    ST_CHECK  = 3'd7
  } step_t;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_RDW   = 3'd1;
  localparam logic [2:0] OP_WRW   = 3'd2;
  localparam logic [2:0] OP_RDB   = 3'd3;
  localparam logic [2:0] OP_WRB   = 3'd4;
  localparam logic [2:0] OP_CSUM  = 3'd5;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_RANGE  = 2'd1;
  localparam logic [1:0] STAT_VERIFY = 2'd2;
  localparam logic [1:0] STAT_CSUM   = 2'd3;

  localparam logic [15:0] TARGET_RST = 16'hBABA;
  localparam logic [7:0]  LAST_WORD  = 8'(WORDS - 1);
  localparam logic [7:0]  LAST_SUM   = 8'(WORDS - 2);

  localparam logic [2:0] CFG_TARGET = 3'd0;

  // Frame image for a step, cut to 28 bits.
  function automatic logic [27:0] frame_f(step_t st, logic [7:0] waddr,
                                          logic [7:0] widx, logic [15:0] word);
    logic [31:0] f;
    case (st)
      ST_EWEN:  f = (32'd4 << 22) | (32'd48 << 16);
      ST_WRITE: f = (32'd5 << 22) | ({24'd0, waddr} << 16) | {16'd0, word};
      ST_EWDS:  f = 32'd4 << 22;
      ST_SUM, ST_CHECK: f = (32'd6 << 22) | ({24'd0, widx} << 16);
      default:  f = (32'd6 << 22) | ({24'd0, waddr} << 16);
    endcase
    return f[27:0];
  endfunction

endpackage

### hw/rtl/microwire_eeprom_master_unit.sv
// Top level of the Microwire EEPROM master: sequencer, pin framing, result register.
// Depends on mwem_pkg.
//
// Each accepted input beat is one pin tick: the block drives CS, SK and DI for that tick
// and returns one result beat carrying the pin levels, busy/done, read data and status.
// A beat is processed by the combinational sequencer logic that sits between the state
// registers and the result register, so a new beat is accepted on every cycle while the
// result register is empty or being drained; throughput is one beat per clock. Commands
// (op 1..5) are taken only while idle and ignored while a sequence runs. Each transfer is
// a start tick (CS, SK high), two ticks per frame bit, then CS-only and a release tick.
// Reads use 26-bit frames, EWEN/WRITE/EWDS use 28-bit frames. The checksum target is an
// APB register at address 0 (reset 0xBABA); write it only while no command runs.
module microwire_eeprom_master_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_address,
  input  logic [15:0] in_write_data,
  input  logic        in_serial_data_out,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_chip_select,
  output logic        out_shift_clock,
  output logic        out_serial_data_in,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [15:0] out_read_data,
  output logic [1:0]  out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // state registers
  mwem_pkg::step_t step_r, step_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [5:0]  phase_r, phase_nxt;
  logic [27:0] tx_r, tx_nxt;
  logic [15:0] rx_r, rx_nxt;
  logic [7:0]  widx_r, widx_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [15:0] word_r, word_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] target_r;

  // result register
  logic        ov_r;
  logic        cs_r, sk_r, di_r, busy_r, done_r;
  logic [15:0] rd_r;
  logic [1:0]  st_r;
  logic        cs_n, sk_n, di_n, busy_n, done_n;
  logic [15:0] rd_n;
  logic [1:0]  st_n;

  logic        take;

  assign in_ready = !ov_r || out_ready;
  assign take     = in_valid && in_ready;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == {mwem_pkg::CFG_TARGET[1:0]}) ? {16'd0, target_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= mwem_pkg::TARGET_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr == mwem_pkg::CFG_TARGET[1:0]) begin
      target_r <= cfg_pwdata[15:0];
    end
  end

  // Sequencer: one tick of the model per accepted beat.
  always_comb begin
    mwem_pkg::step_t st0;
    logic [2:0]  cmd0;
    logic [5:0]  t;
    logic [27:0] tx0;
    logic [15:0] rx0;
    logic [7:0]  widx0, addr0, waddr, woff;
    logic [15:0] word0, sum0, w;
    logic [5:0]  nb2;
    logic [4:0]  pos;
    logic        start, abort, fin;
    mwem_pkg::step_t ld;
    logic        do_ld;

    step_nxt = step_r; cmd_nxt = cmd_r; phase_nxt = phase_r; tx_nxt = tx_r;
    rx_nxt = rx_r; widx_nxt = widx_r; addr_nxt = addr_r; word_nxt = word_r;
    sum_nxt = sum_r;
    cs_n = 1'b0; sk_n = 1'b0; di_n = 1'b0; busy_n = 1'b0; done_n = 1'b0;
    rd_n = 16'd0; st_n = mwem_pkg::STAT_OK;

    st0 = step_r; cmd0 = cmd_r; t = phase_r; tx0 = tx_r; rx0 = rx_r;
    widx0 = widx_r; addr0 = addr_r; word0 = word_r; sum0 = sum_r;
    start = 1'b0; abort = 1'b0;
    woff = (in_op == mwem_pkg::OP_RDB || in_op == mwem_pkg::OP_WRB)
           ? {1'b0, in_address[7:1]} : in_address;
    ld = mwem_pkg::ST_IDLE; do_ld = 1'b0;
    waddr = 8'd0; nb2 = 6'd0; pos = 5'd0; fin = 1'b0; w = 16'd0;

    if (step_r == mwem_pkg::ST_IDLE) begin
      if (in_op >= mwem_pkg::OP_RDW && in_op <= mwem_pkg::OP_CSUM) begin
        if (in_op != mwem_pkg::OP_CSUM && woff > mwem_pkg::LAST_WORD) begin
          abort = 1'b1;
        end else begin
          start = 1'b1;
          cmd0 = in_op; addr0 = in_address; t = 6'd0; rx0 = 16'd0;
          case (in_op)
            mwem_pkg::OP_WRW: begin
              word0 = in_write_data; st0 = mwem_pkg::ST_EWEN;
            end
            mwem_pkg::OP_CSUM: begin
              addr0 = mwem_pkg::LAST_WORD; widx0 = 8'd0; sum0 = 16'd0;
              st0 = mwem_pkg::ST_SUM;
            end
            default: begin
              word0 = (in_op == mwem_pkg::OP_WRB) ? {8'd0, in_write_data[7:0]} : 16'd0;
              st0 = mwem_pkg::ST_PRE;
            end
          endcase
          waddr = (cmd0 == mwem_pkg::OP_RDB || cmd0 == mwem_pkg::OP_WRB)
                  ? {1'b0, addr0[7:1]} : addr0;
          tx0 = mwem_pkg::frame_f(st0, waddr, widx0, word0);
        end
      end
    end

    if (abort) begin
      done_n = 1'b1; st_n = mwem_pkg::STAT_RANGE;
    end else if (start || step_r != mwem_pkg::ST_IDLE) begin
      nb2 = (st0 == mwem_pkg::ST_EWEN || st0 == mwem_pkg::ST_WRITE
             || st0 == mwem_pkg::ST_EWDS) ? 6'd56 : 6'd52;
      if (t >= 6'd3 && t[0] && t <= nb2 + 6'd1) rx0 = {rx0[14:0], in_serial_data_out};
      if (t == 6'd0) begin
        cs_n = 1'b1; sk_n = 1'b1;
      end else if (t <= nb2) begin
        pos = 5'(nb2[5:1] - 6'd1 - 6'((t - 6'd1) >> 1));
        cs_n = 1'b1; sk_n = !t[0]; di_n = tx0[pos];
      end else if (t == nb2 + 6'd1) begin
        cs_n = 1'b1;
      end
      fin = 1'b0;
      w = rx0;
      if (t >= nb2 + 6'd2) begin
        case (st0)
          mwem_pkg::ST_PRE: begin
            if (cmd0 == mwem_pkg::OP_WRB) begin
              word0 = addr0[0] ? {word0[7:0], w[7:0]} : {w[15:8], word0[7:0]};
              ld = mwem_pkg::ST_EWEN; do_ld = 1'b1;
            end else begin
              fin = 1'b1;
              rd_n = (cmd0 == mwem_pkg::OP_RDB)
                     ? (addr0[0] ? {8'd0, w[15:8]} : {8'd0, w[7:0]}) : w;
            end
          end
          mwem_pkg::ST_EWEN:  begin ld = mwem_pkg::ST_WRITE; do_ld = 1'b1; end
          mwem_pkg::ST_WRITE: begin ld = mwem_pkg::ST_EWDS; do_ld = 1'b1; end
          mwem_pkg::ST_EWDS: begin
            do_ld = 1'b1;
            if (cmd0 == mwem_pkg::OP_CSUM) begin
              widx0 = 8'd0; sum0 = 16'd0; ld = mwem_pkg::ST_CHECK;
            end else begin
              ld = mwem_pkg::ST_VERIFY;
            end
          end
          mwem_pkg::ST_VERIFY: begin
            fin = 1'b1; rd_n = w;
            st_n = (w == word0) ? mwem_pkg::STAT_OK : mwem_pkg::STAT_VERIFY;
          end
          mwem_pkg::ST_SUM: begin
            sum0 = sum0 + w; do_ld = 1'b1;
            if (widx0 >= mwem_pkg::LAST_SUM) begin
              word0 = target_r - sum0; ld = mwem_pkg::ST_EWEN;
            end else begin
              widx0 = widx0 + 8'd1; ld = mwem_pkg::ST_SUM;
            end
          end
          default: begin
            sum0 = sum0 + w;
            if (widx0 >= mwem_pkg::LAST_WORD) begin
              fin = 1'b1; rd_n = word0;
              st_n = (sum0 == target_r) ? mwem_pkg::STAT_OK : mwem_pkg::STAT_CSUM;
            end else begin
              widx0 = widx0 + 8'd1; ld = mwem_pkg::ST_CHECK; do_ld = 1'b1;
            end
          end
        endcase
        if (fin) begin
          st0 = mwem_pkg::ST_IDLE; t = 6'd0; done_n = 1'b1;
        end else begin
          busy_n = 1'b1;
        end
        if (do_ld) begin
          waddr = (cmd0 == mwem_pkg::OP_RDB || cmd0 == mwem_pkg::OP_WRB)
                  ? {1'b0, addr0[7:1]} : addr0;
          st0 = ld; tx0 = mwem_pkg::frame_f(ld, waddr, widx0, word0);
          rx0 = 16'd0; t = 6'd0;
        end
      end else begin
        t = t + 6'd1; busy_n = 1'b1;
      end
      if (!done_n) begin
        rd_n = 16'd0; st_n = mwem_pkg::STAT_OK;
      end
      step_nxt = st0; cmd_nxt = cmd0; phase_nxt = t; tx_nxt = tx0; rx_nxt = rx0;
      widx_nxt = widx0; addr_nxt = addr0; word_nxt = word0; sum_nxt = sum0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= mwem_pkg::ST_IDLE;
      cmd_r <= 3'd0; phase_r <= 6'd0; tx_r <= 28'd0; rx_r <= 16'd0;
      widx_r <= 8'd0; addr_r <= 8'd0; word_r <= 16'd0; sum_r <= 16'd0;
      ov_r <= 1'b0;
    end else begin
      if (take) begin
        step_r <= step_nxt; cmd_r <= cmd_nxt; phase_r <= phase_nxt; tx_r <= tx_nxt;
        rx_r <= rx_nxt; widx_r <= widx_nxt; addr_r <= addr_nxt; word_r <= word_nxt;
        sum_r <= sum_nxt;
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Result payload: load on every accepted beat.
  always_ff @(posedge clk) begin
    if (take) begin
      cs_r <= cs_n; sk_r <= sk_n; di_r <= di_n; busy_r <= busy_n; done_r <= done_n;
      rd_r <= rd_n; st_r <= st_n;
    end
  end

  assign out_valid          = ov_r;
  assign out_chip_select    = cs_r;
  assign out_shift_clock    = sk_r;
  assign out_serial_data_in = di_r;
  assign out_busy_res       = busy_r;
  assign out_done_res       = done_r;
  assign out_read_data      = rd_r;
  assign out_status         = st_r;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for microwire_eeprom_master_unit: a pin-level EEPROM model answers the
// generated Microwire frames; a cycle-true predictor or a typed-in beat checks each result beat.
// Depends on mwem_pkg and the RTL of the block.
module tb_top;
  import mwem_pkg::*;

  // One result beat: the pin levels of one tick and the command outcome.
  typedef struct packed {
    logic        cs;
    logic        sk;
    logic        di;
    logic        busy;
    logic        done;
    logic [15:0] rd;
    logic [1:0]  stat;
  } tick_res_t;

  // EEPROM answer modes for one command.
  localparam int EE_TRUE  = 0;  // a well-behaved part
  localparam int EE_NOISE = 1;  // DO line carries random levels
  localparam int EE_WP    = 2;  // part ignores writes, verify fails

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  addr;
    logic [15:0] wd;
    int          mode;
    bit          fixed;   // expected beat typed in below
    tick_res_t   res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [7:0]  in_address;
  logic [15:0] in_write_data;
  logic        in_serial_data_out;
  logic        out_valid;
  logic        out_ready;
  logic        out_chip_select;
  logic        out_shift_clock;
  logic        out_serial_data_in;
  logic        out_busy_res;
  logic        out_done_res;
  logic [15:0] out_read_data;
  logic [1:0]  out_status;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  microwire_eeprom_master_unit dut (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Expected result beats, oldest first.
  tick_res_t pin_tick_q[$];
  int        fail_cnt;
  int        beats_sent;
  bit        calm;        // no idling on either side while set
  bit        stall_hold;  // long receiver hold-off

  // ---------------------------------------------------------------------------
  // Predictor state: a copy of the sequencer, kept in step with accepted beats.
  // ---------------------------------------------------------------------------
  step_t       seq_step;
  logic [2:0]  cmd_q;
  int unsigned phase;
  logic [27:0] tx_sr;
  logic [15:0] rx_sr;
  logic [7:0]  widx;
  logic [7:0]  hold_addr;
  logic [15:0] hold_word;
  logic [15:0] acc_sum;
  logic [15:0] target;

  // Byte commands address words by half the byte offset.
  function automatic logic [7:0] word_off();
    return (cmd_q == OP_RDB || cmd_q == OP_WRB) ? (hold_addr >> 1) : hold_addr;
  endfunction

  function automatic void start_frame(step_t st);
    logic [31:0] img;
    case (st)
      ST_EWEN:          img = 32'h0130_0000;                        // opcode 100, 11xxxx
      ST_WRITE:         img = 32'h0140_0000 | (32'(word_off()) << 16) | 32'(hold_word);
      ST_EWDS:          img = 32'h0100_0000;
      ST_SUM, ST_CHECK: img = 32'h0180_0000 | (32'(widx) << 16);
      default:          img = 32'h0180_0000 | (32'(word_off()) << 16);
    endcase
    seq_step = st;
    tx_sr    = img[27:0];
    rx_sr    = '0;
    phase    = 0;
  endfunction

  // Close a transfer; returns 1 when the command has finished.
  function automatic bit close_frame(output logic [15:0] rd, output logic [1:0] stat);
    logic [15:0] w;
    w    = rx_sr;
    rd   = '0;
    stat = STAT_OK;
    case (seq_step)
      ST_PRE: begin
        if (cmd_q == OP_WRB) begin
          // merge the new byte into the word just read
          if (hold_addr[0]) hold_word = {hold_word[7:0], w[7:0]};
          else hold_word = {w[15:8], hold_word[7:0]};
          start_frame(ST_EWEN);
          return 0;
        end
        if (cmd_q == OP_RDB) rd = hold_addr[0] ? {8'd0, w[15:8]} : {8'd0, w[7:0]};
        else rd = w;
        return 1;
      end
      ST_EWEN: begin
        start_frame(ST_WRITE);
        return 0;
      end
      ST_WRITE: begin
        start_frame(ST_EWDS);
        return 0;
      end
      ST_EWDS: begin
        if (cmd_q == OP_CSUM) begin
          widx    = '0;
          acc_sum = '0;
          start_frame(ST_CHECK);
        end else begin
          start_frame(ST_VERIFY);
        end
        return 0;
      end
      ST_VERIFY: begin
        rd   = w;
        stat = (w == hold_word) ? STAT_OK : STAT_VERIFY;
        return 1;
      end
      ST_SUM: begin
        acc_sum = acc_sum + w;
        if (widx >= 8'(WORDS - 2)) begin
          hold_word = target - acc_sum;
          start_frame(ST_EWEN);
        end else begin
          widx = widx + 8'd1;
          start_frame(ST_SUM);
        end
        return 0;
      end
      default: begin
        acc_sum = acc_sum + w;
        if (widx >= 8'(WORDS - 1)) begin
          rd   = hold_word;
          stat = (acc_sum == target) ? STAT_OK : STAT_CSUM;
          return 1;
        end
        widx = widx + 8'd1;
        start_frame(ST_CHECK);
        return 0;
      end
    endcase
  endfunction

  // Pin levels and outcome of one tick.
  function automatic tick_res_t predict_tick(logic [2:0] op, logic [7:0] addr,
                                             logic [15:0] wd, logic dout);
    tick_res_t   r;
    logic [7:0]  woff;
    int unsigned nb;
    int unsigned pos;
    logic [15:0] rd;
    logic [1:0]  stat;
    r = '0;
    if (seq_step == ST_IDLE) begin
      if (op < OP_RDW || op > OP_CSUM) return r;
      woff = (op == OP_RDB || op == OP_WRB) ? (addr >> 1) : addr;
      if (op != OP_CSUM && woff > LAST_WORD) begin
        r.done = 1'b1;
        r.stat = STAT_RANGE;
        return r;
      end
      cmd_q     = op;
      hold_addr = addr;
      if (op == OP_WRW) begin
        hold_word = wd;
        start_frame(ST_EWEN);
      end else if (op == OP_CSUM) begin
        hold_addr = LAST_WORD;
        widx      = '0;
        acc_sum   = '0;
        start_frame(ST_SUM);
      end else begin
        hold_word = (op == OP_WRB) ? {8'd0, wd[7:0]} : 16'd0;
        start_frame(ST_PRE);
      end
    end
    nb = (seq_step == ST_EWEN || seq_step == ST_WRITE || seq_step == ST_EWDS) ? 28 : 26;
    // shift in the DO level of the previous SK-high tick
    if (phase >= 3 && phase[0] && phase <= 2 * nb + 1) rx_sr = {rx_sr[14:0], dout};
    if (phase == 0) begin
      r.cs = 1'b1;
      r.sk = 1'b1;
    end else if (phase <= 2 * nb) begin
      pos  = nb - 1 - ((phase - 1) >> 1);
      r.cs = 1'b1;
      r.sk = !phase[0];
      r.di = tx_sr[pos];
    end else if (phase == 2 * nb + 1) begin
      r.cs = 1'b1;
    end
    if (phase >= 2 * nb + 2) begin
      if (close_frame(rd, stat)) begin
        seq_step = ST_IDLE;
        phase    = 0;
        r.done   = 1'b1;
        r.rd     = rd;
        r.stat   = stat;
      end else begin
        r.busy = 1'b1;
      end
    end else begin
      phase  = (phase + 1) & 6'h3F;
      r.busy = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // EEPROM model: decodes frames from the predicted pins and answers on DO.
  // ---------------------------------------------------------------------------
  logic [15:0] ee_mem [WORDS];
  int          ee_mode;
  bit          ee_wen;
  bit          ee_prev_cs;
  bit          ee_prev_sk;
  int          ee_bits;
  logic [27:0] ee_sr;
  logic [5:0]  ee_rd_addr;
  bit          ee_is_rd;
  logic        next_dout;

  function automatic logic eeprom_pins(logic cs, logic sk, logic di);
    logic d;
    d = 1'b0;
    if (!cs) begin
      if (ee_prev_cs && ee_bits == 28) begin
        if (ee_sr[24:22] == 3'b101 && ee_wen && ee_mode != EE_WP)
          ee_mem[ee_sr[21:16]] = ee_sr[15:0];
        else if (ee_sr[24:22] == 3'b100 && ee_sr[21:20] == 2'b11) ee_wen = 1;
        else if (ee_sr[24:22] == 3'b100 && ee_sr[21:20] == 2'b00) ee_wen = 0;
      end
      ee_bits = 0;
    end else if (!ee_prev_cs) begin
      ee_bits  = 0;
      ee_is_rd = 0;
    end else if (sk && !ee_prev_sk) begin
      ee_sr   = {ee_sr[26:0], di};
      ee_bits = ee_bits + 1;
      if (ee_bits == 10) begin
        ee_is_rd   = (ee_sr[8:6] == 3'b110);
        ee_rd_addr = ee_sr[5:0];
      end
      if (ee_is_rd && ee_bits >= 11 && ee_bits <= 26) d = ee_mem[ee_rd_addr][26 - ee_bits];
    end
    ee_prev_cs = cs;
    ee_prev_sk = sk;
    if (ee_mode == EE_NOISE) d = 1'($urandom);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic send_tick(logic [2:0] op, logic [7:0] addr, logic [15:0] wd,
                           bit fixed = 0, tick_res_t fixed_res = '0);
    tick_res_t r;
    logic      d;
    d = next_dout;
    r = predict_tick(op, addr, wd, d);
    pin_tick_q.push_back(fixed ? fixed_res : r);
    next_dout = eeprom_pins(r.cs, r.sk, r.di);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_op              <= op;
    in_address         <= addr;
    in_write_data      <= wd;
    in_serial_data_out <= d;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    calm = (beats_sent >= 1000 && beats_sent < 1400);
  endtask

  // Issue one command, then tick the bus until the sequence is over.
  task automatic run_cmd(logic [2:0] op, logic [7:0] addr, logic [15:0] wd, int mode);
    ee_mode = mode;
    send_tick(op, addr, wd);
    while (seq_step != ST_IDLE) send_tick(3'($urandom), 8'($urandom), 16'($urandom));
    ee_mode = EE_TRUE;
  endtask

  task automatic idle_ticks(int n);
    logic [2:0] op;
    repeat (n) begin
      case ($urandom_range(2))
        0:       op = OP_TICK;
        1:       op = 3'd6;
        default: op = 3'd7;
      endcase
      send_tick(op, 8'($urandom), 16'($urandom));
    end
  endtask

  // Drain all results, then write the checksum target.
  task automatic set_target(logic [15:0] value);
    in_valid <= 1'b0;
    while (pin_tick_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 2'(CFG_TARGET << 2);
    cfg_pwdata  <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    target = value;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h (beat %0d)", what, got, want, beats_sent);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    tick_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pin_tick_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          want = pin_tick_q.pop_front();
          if (out_chip_select !== want.cs) report("cs", out_chip_select, want.cs);
          if (out_shift_clock !== want.sk) report("sk", out_shift_clock, want.sk);
          if (out_serial_data_in !== want.di) report("di", out_serial_data_in, want.di);
          if (out_busy_res !== want.busy) report("busy", out_busy_res, want.busy);
          if (out_done_res !== want.done) report("done", out_done_res, want.done);
          if (out_read_data !== want.rd) report("read_data", out_read_data, want.rd);
          if (out_status !== want.stat) report("status", out_status, want.stat);
        end
      end
      out_ready <= !stall_hold && (calm || $urandom_range(99) >= 14);
    end
  end

  // Long receiver hold-off while the sender keeps offering beats.
  initial begin
    stall_hold = 0;
    wait (beats_sent >= 300);
    @(posedge clk);
    stall_hold <= 1'b1;
    repeat (300) @(posedge clk);
    stall_hold <= 1'b0;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  // Directed table: idle ticks and range errors carry their beat; the rest use the
  // predictor.
  stim_row_t rows [] = '{
    '{OP_TICK, 8'hFF, 16'hFFFF, EE_TRUE, 1, '0},
    '{3'd6,    8'h00, 16'h0000, EE_TRUE, 1, '0},
    '{3'd7,    8'hFF, 16'hFFFF, EE_TRUE, 1, '0},
    '{OP_RDW,  8'd64, 16'h0000, EE_TRUE, 1, '{0, 0, 0, 0, 1, 16'h0, STAT_RANGE}},
    '{OP_RDW,  8'hFF, 16'hFFFF, EE_TRUE, 1, '{0, 0, 0, 0, 1, 16'h0, STAT_RANGE}},
    '{OP_WRW,  8'd64, 16'h1234, EE_TRUE, 1, '{0, 0, 0, 0, 1, 16'h0, STAT_RANGE}},
    '{OP_RDB,  8'd128, 16'h0000, EE_TRUE, 1, '{0, 0, 0, 0, 1, 16'h0, STAT_RANGE}},
    '{OP_WRB,  8'hFF, 16'hFFFF, EE_TRUE, 1, '{0, 0, 0, 0, 1, 16'h0, STAT_RANGE}},
    '{OP_RDW,  8'd0,  16'h0000, EE_TRUE, 0, '0},
    '{OP_RDW,  8'd63, 16'hFFFF, EE_TRUE, 0, '0},
    '{OP_WRW,  8'd0,  16'hFFFF, EE_TRUE, 0, '0},
    '{OP_WRW,  8'd63, 16'h0000, EE_TRUE, 0, '0},
    '{OP_RDB,  8'd0,  16'h0000, EE_TRUE, 0, '0},
    '{OP_RDB,  8'd127, 16'h0000, EE_TRUE, 0, '0},
    '{OP_WRB,  8'd1,  16'hFFA5, EE_TRUE, 0, '0},
    '{OP_WRB,  8'd126, 16'h00FF, EE_TRUE, 0, '0},
    '{OP_WRW,  8'd5,  16'hA5A5, EE_WP,   0, '0},
    '{OP_RDW,  8'd9,  16'h0000, EE_NOISE, 0, '0},
    '{OP_RDW,  8'd63, 16'h0000, EE_TRUE, 0, '0}
  };

  initial begin
    int          mode;
    logic [2:0]  op;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_op              = '0;
    in_address         = '0;
    in_write_data      = '0;
    in_serial_data_out = 1'b0;
    out_ready          = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    fail_cnt           = 0;
    beats_sent         = 0;
    calm               = 0;
    // predictor and EEPROM after reset
    seq_step   = ST_IDLE;
    cmd_q      = OP_TICK;
    phase      = 0;
    tx_sr      = '0;
    rx_sr      = '0;
    widx       = '0;
    hold_addr  = '0;
    hold_word  = '0;
    acc_sum    = '0;
    target     = TARGET_RST;
    ee_mode    = EE_TRUE;
    ee_wen     = 0;
    ee_prev_cs = 0;
    ee_prev_sk = 0;
    ee_bits    = 0;
    ee_sr      = '0;
    ee_rd_addr = '0;
    ee_is_rd   = 0;
    next_dout  = 1'b0;
    foreach (ee_mem[i]) ee_mem[i] = 16'($urandom);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].fixed && rows[i].op != OP_TICK && rows[i].op < 3'd6) begin
        ee_mode = rows[i].mode;
        send_tick(rows[i].op, rows[i].addr, rows[i].wd, 1, rows[i].res);
      end else if (rows[i].fixed) begin
        send_tick(rows[i].op, rows[i].addr, rows[i].wd, 1, rows[i].res);
      end else begin
        run_cmd(rows[i].op, rows[i].addr, rows[i].wd, rows[i].mode);
      end
    end

    // Random phases, each under its own target register value; extremes first.
    for (int ph = 0; ph < 3; ph++) begin
      set_target(ph == 0 ? 16'hFFFF : ph == 1 ? 16'h0000 : 16'($urandom));
      while (beats_sent < 1700 + 150 * ph) begin
        mode = $urandom_range(99);
        mode = (mode < 85) ? EE_TRUE : (mode < 93) ? EE_NOISE : EE_WP;
        op   = 3'($urandom_range(4, 1));
        // mostly in-range offsets, some out of range
        if ($urandom_range(9) == 0)
          run_cmd(op, 8'($urandom), 16'($urandom), mode);
        else if (op == OP_RDB || op == OP_WRB)
          run_cmd(op, 8'($urandom_range(127)), 16'($urandom), mode);
        else
          run_cmd(op, 8'($urandom_range(63)), 16'($urandom), mode);
        idle_ticks($urandom_range(3));
      end
    end

    in_valid <= 1'b0;
    while (pin_tick_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### microwire_eeprom_master_unit.f
hw/rtl/mwem_pkg.sv
hw/rtl/microwire_eeprom_master_unit.sv
tb/sv/tb_top.sv
